### sv/fseq_pkg.sv
package fseq_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = 5;
   localparam int TIMER_W    = 32;
   localparam int ELAPSED_W  = 16;
   localparam int SPEED_W    = 12;
   localparam int INC_W      = ELAPSED_W + SPEED_W;
   localparam int DUR_W      = 16;
   localparam int FRAC_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // play modes
   localparam logic [1:0] MODE_ONCE      = 2'd0;
   localparam logic [1:0] MODE_OSCILLATE = 2'd1;
   localparam logic [1:0] MODE_LOOP      = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

   typedef struct packed {
      logic [TIMER_W-1:0] timer;
      logic [IDX_W-1:0]   pos;
      logic               dir_up;
      logic               running;
   } seq_state_type;

   typedef struct packed {
      logic [1:0]         play_mode;
      logic [COUNT_W-1:0] frame_count;
   } seq_cfg_type;

endpackage

### sv/fseq_dur_table.sv
module fseq_dur_table
   import fseq_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [DUR_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [DUR_W-1:0] rd_data
);

   logic [DUR_W-1:0] dur_ff [MAX_FRAMES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dur_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = dur_ff[rd_addr];

endmodule

### sv/fseq_update.sv
module fseq_update
   import fseq_pkg::*;
(
   input  logic [1:0]         kind,
   input  logic [INC_W-1:0]   inc,
   input  seq_state_type      cur,
   input  seq_cfg_type        cfg,
   input  logic [DUR_W-1:0]   dur_rd,
   output logic [IDX_W-1:0]   rd_addr,
   output seq_state_type      nxt,
   output logic               advanced,
   output logic               playing
);

   logic [COUNT_W-1:0] n_used;
   logic [COUNT_W-1:0] n_last;
   logic               active;
   logic [IDX_W-1:0]   pos_c;
   logic [TIMER_W:0]   sum;
   logic               counting;
   logic               at_end;
   logic               new_dir;

   always_comb begin
      n_used = (cfg.frame_count > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                       : cfg.frame_count;
      n_last = n_used - COUNT_W'(1);
      active = cur.running && (n_used != '0);
      // clamp a stale position to the last frame
      pos_c  = ({1'b0, cur.pos} >= n_used) ? n_last[IDX_W-1:0] : cur.pos;
      rd_addr = pos_c;
      sum      = {1'b0, cur.timer} + {{(TIMER_W+1-INC_W){1'b0}}, inc};
      counting = (dur_rd != '0) &&
                 (cur.timer < {{(TIMER_W-DUR_W-FRAC_W){1'b0}}, dur_rd, {FRAC_W{1'b0}}});
      at_end   = cur.dir_up ? ({1'b0, pos_c} == n_last) : (pos_c == '0);
      new_dir  = cur.dir_up;

      nxt      = cur;
      advanced = 1'b0;

      unique case (kind)
         KIND_TICK: begin
            if (active) begin
               nxt.pos = pos_c;
               if (counting) begin
                  nxt.timer = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
               end else begin
                  nxt.timer = '0;
                  advanced  = 1'b1;
                  if (!at_end) begin
                     nxt.pos = cur.dir_up ? pos_c + IDX_W'(1) : pos_c - IDX_W'(1);
                  end else begin
                     priority if (cfg.play_mode == MODE_OSCILLATE) begin
                        new_dir    = !cur.dir_up;
                        nxt.dir_up = new_dir;
                        nxt.pos    = new_dir ? '0 : n_last[IDX_W-1:0];
                     end else if (cfg.play_mode == MODE_LOOP) begin
                        nxt.pos = cur.dir_up ? '0 : n_last[IDX_W-1:0];
                     end else begin
                        nxt.running = 1'b0;
                     end
                  end
               end
            end
         end
         KIND_LOAD: begin
            nxt.pos = (cur.dir_up || (n_used == '0)) ? '0 : n_last[IDX_W-1:0];
         end
         KIND_START: begin
            nxt.running = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase

      playing = nxt.running && (n_used != '0);
   end

endmodule

### sv/frame_sequencer_once_loop_pingpong_core.sv
// Sprite animation frame sequencer. Each request is a time tick, a frame
// duration load, or a start command, and each request returns exactly one
// response with the frame now shown, the playing and direction flags, and
// whether this tick ended the frame. Ticks grow a 32-bit timer (8 fraction
// bits) by elapsed * speed_q4_8 until it reaches duration * 256; the next
// tick then moves one frame in the current direction, with once, loop or
// oscillate behavior at the sequence end. Throughput is one request per
// cycle while rsp_ready stays high. A request passes through the input
// register, where the speed product is formed, and then the update into
// the response register, which makes its response valid. A response held
// by a low rsp_ready stalls the update stage, and req_ready drops once the
// input register is also full. csr_* writes are only expected while idle.
module frame_sequencer_once_loop_pingpong_core
   import fseq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [ELAPSED_W-1:0]  req_elapsed,
   input  logic [3:0]            req_entry_index,
   input  logic [DUR_W-1:0]      req_entry_duration,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_current_frame,
   output logic                  rsp_is_playing,
   output logic                  rsp_going_forward,
   output logic                  rsp_advanced,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [1:0]         play_mode_ff;
   logic [SPEED_W-1:0] speed_ff;
   logic [COUNT_W-1:0] frame_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         play_mode_ff   <= MODE_ONCE;
         speed_ff       <= SPEED_RESET;
         frame_count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLAY_MODE:   play_mode_ff   <= csr_wdata[1:0];
            CSR_SPEED:       speed_ff       <= csr_wdata[SPEED_W-1:0];
            CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: holds one request; the scaled increment is formed here
   // so the update stage only sees an add and compare
   logic               in_valid_ff;
   logic [1:0]         in_kind_ff;
   logic [INC_W-1:0]   in_inc_ff;
   logic [IDX_W-1:0]   in_slot_ff;
   logic [DUR_W-1:0]   in_dur_ff;
   logic               req_fire;
   logic               step_go;

   // the update stage fires when the response register is free or draining
   assign step_go   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || step_go;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind;
         in_inc_ff  <= INC_W'(req_elapsed) * INC_W'(speed_ff);
         in_slot_ff <= req_entry_index[IDX_W-1:0];
         in_dur_ff  <= req_entry_duration;
      end
   end

   // sequencer state
   seq_state_type state_ff;
   seq_state_type state_in;
   seq_cfg_type   cfg;
   logic [IDX_W-1:0] rd_addr;
   logic [DUR_W-1:0] dur_rd;
   logic             adv;
   logic             playing;

   assign cfg.play_mode   = play_mode_ff;
   assign cfg.frame_count = frame_count_ff;

   // duration table; entries have no reset, loads fill them
   fseq_dur_table u_table (
      .clock   (clock),
      .wr_en   (step_go && (in_kind_ff == KIND_LOAD)),
      .wr_addr (in_slot_ff),
      .wr_data (in_dur_ff),
      .rd_addr (rd_addr),
      .rd_data (dur_rd)
   );

   fseq_update u_update (
      .kind     (in_kind_ff),
      .inc      (in_inc_ff),
      .cur      (state_ff),
      .cfg      (cfg),
      .dur_rd   (dur_rd),
      .rd_addr  (rd_addr),
      .nxt      (state_in),
      .advanced (adv),
      .playing  (playing)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.timer   <= '0;
         state_ff.pos     <= '0;
         state_ff.dir_up  <= 1'b1;
         state_ff.running <= 1'b0;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   // response register
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_frame_ff;
   logic             rsp_playing_ff;
   logic             rsp_fwd_ff;
   logic             rsp_adv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_frame_ff   <= state_in.pos;
         rsp_playing_ff <= playing;
         rsp_fwd_ff     <= state_in.dir_up;
         rsp_adv_ff     <= adv;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_frame = 4'(rsp_frame_ff);
   assign rsp_is_playing    = rsp_playing_ff;
   assign rsp_going_forward = rsp_fwd_ff;
   assign rsp_advanced      = rsp_adv_ff;

endmodule
